FILE: rtl/core/sart_pkg.sv
// Shared types and constants for the sorted address range table.
// No dependencies; used by every module in rtl/core except sart_ram.
package sart_pkg;

   localparam int DEPTH     = 128;
   localparam int ADDR_BITS = 48;
   localparam int TAG_BITS  = 16;
   localparam int LEN_BITS  = 32;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int ENT_W     = TAG_BITS + LEN_BITS + ADDR_BITS;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_RENAMED   = 3'd1,
      ST_UNCHANGED = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_TRIMMED   = 3'd4,
      ST_NOTFOUND  = 3'd5,
      ST_FULL      = 3'd6,
      ST_FOUND     = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_RD, S_CMP, S_ACT, S_INS, S_INSW, S_RMV, S_RMVW, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      UPD_TAG, UPD_TRIM_START, UPD_TRIM_END
   } upd_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic [LEN_BITS-1:0]  len;
      logic [ADDR_BITS-1:0] base;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       init;
      logic       probe_rd;
      logic       probe_cmp;
      logic       ins_begin;
      logic       ins_rd;
      logic       ins_wr;
      logic       rm_begin;
      logic       rm_rd;
      logic       rm_wr;
      logic       new_wr;
      logic       upd_wr;
      upd_type    upd;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       res_load;
      status_type res_code;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      mode_type         mode;
      logic             skip_hit;
      logic             empty;
      logic             lt;
      logic             le;
      logic             lo_eq;
      logic             hit;
      logic             full;
      logic             add_exact;
      logic             rm_exact;
      logic             base_eq;
      logic             end_eq;
      logic             ins_done;
      logic             rm_done;
      logic             out_free;
      logic [CNT_W-1:0] count;
   } st_type;

endpackage

FILE: rtl/core/sart_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sart_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/core/sart_dp.sv
// Datapath: request registers, search bounds, entry RAM, compares, result register.
// Depends on sart_pkg and sart_ram.
module sart_dp (
   input  logic             clock,
   input  logic             reset,
   input  sart_pkg::cmd_type cmd,
   output sart_pkg::st_type  st,
   input  logic [103:0]     req_tdata,
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [87:0]      rsp_tdata
);

   sart_pkg::mode_type              mode_ff;
   logic [sart_pkg::ADDR_BITS-1:0]  a_ff;
   logic [sart_pkg::LEN_BITS-1:0]   sz_ff;
   logic [sart_pkg::TAG_BITS-1:0]   tag_ff;
   logic                            skip_ff;
   logic [sart_pkg::IDX_W-1:0]      lo_ff, hi_ff, i_ff;
   logic [sart_pkg::CNT_W-1:0]      k_ff, j_ff, count_ff;
   logic                            hit_ff;
   sart_pkg::entry_type             ent_ff;
   sart_pkg::status_type            res_st_ff;
   logic [sart_pkg::TAG_BITS-1:0]   res_tag_ff;
   logic [sart_pkg::LEN_BITS-1:0]   res_len_ff, res_off_ff;
   logic                            rsp_valid_ff;
   logic [87:0]                     rsp_data_ff;

   sart_pkg::entry_type             rd_ent, wr_ent;
   logic                            wr_en;
   logic [sart_pkg::IDX_W-1:0]      wr_addr, rd_addr, mid;
   logic [sart_pkg::ADDR_BITS:0]    s1, s2, e2;

   sart_ram #(.WIDTH(sart_pkg::ENT_W), .DEPTH(sart_pkg::DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_ent)
   );

   always_comb begin
      mid = lo_ff + ((hi_ff - lo_ff) >> 1);
      s1  = {1'b0, a_ff} + (sart_pkg::ADDR_BITS + 1)'(sz_ff);
      s2  = {1'b0, rd_ent.base} + (sart_pkg::ADDR_BITS + 1)'(rd_ent.len);
      e2  = {1'b0, ent_ff.base} + (sart_pkg::ADDR_BITS + 1)'(ent_ff.len);

      rd_addr = mid;
      if (cmd.ins_rd) begin
         rd_addr = sart_pkg::IDX_W'(j_ff - 1'b1);
      end else if (cmd.rm_rd) begin
         rd_addr = sart_pkg::IDX_W'(j_ff + 1'b1);
      end

      wr_en   = cmd.ins_wr | cmd.rm_wr | cmd.new_wr | cmd.upd_wr;
      wr_addr = j_ff[sart_pkg::IDX_W-1:0];
      wr_ent  = rd_ent;
      if (cmd.new_wr) begin
         wr_addr = k_ff[sart_pkg::IDX_W-1:0];
         wr_ent  = '{tag: tag_ff, len: sz_ff, base: a_ff};
      end else if (cmd.upd_wr) begin
         wr_addr = k_ff[sart_pkg::IDX_W-1:0];
         wr_ent  = ent_ff;
         case (cmd.upd)
            sart_pkg::UPD_TAG: wr_ent.tag = tag_ff;
            sart_pkg::UPD_TRIM_START: begin
               wr_ent.base = ent_ff.base + sart_pkg::ADDR_BITS'(sz_ff);
               wr_ent.len  = ent_ff.len - sz_ff;
            end
            default: wr_ent.len = ent_ff.len - sz_ff;
         endcase
      end

      st.mode      = mode_ff;
      st.skip_hit  = skip_ff && (a_ff == '0);
      st.empty     = (count_ff == '0);
      st.lt        = a_ff < rd_ent.base;
      st.le        = s1 <= s2;
      st.lo_eq     = (lo_ff == hi_ff);
      st.hit       = hit_ff;
      st.full      = (count_ff >= sart_pkg::CNT_W'(sart_pkg::DEPTH)) || (k_ff > count_ff);
      st.add_exact = (ent_ff.base == a_ff) && (ent_ff.len == sz_ff);
      st.rm_exact  = (ent_ff.base == a_ff) && ((ent_ff.len == sz_ff) || (sz_ff == '0));
      st.base_eq   = (ent_ff.base == a_ff);
      st.end_eq    = (s1 == e2);
      st.ins_done  = (j_ff == k_ff);
      st.rm_done   = ((j_ff + 1'b1) == count_ff);
      st.out_free  = !rsp_valid_ff || rsp_tready;
      st.count     = count_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= sart_pkg::mode_type'(req_tuser);
         a_ff    <= req_tdata[47:0];
         sz_ff   <= (req_tuser == sart_pkg::MODE_LOOKUP) ? '0 : req_tdata[79:48];
         tag_ff  <= req_tdata[95:80];
         skip_ff <= req_tdata[96];
      end
      if (cmd.init) begin
         lo_ff  <= '0;
         hi_ff  <= sart_pkg::IDX_W'(count_ff - 1'b1);
         hit_ff <= 1'b0;
         k_ff   <= '0;
      end
      if (cmd.probe_rd) begin
         i_ff <= mid;
      end
      if (cmd.probe_cmp) begin
         ent_ff <= rd_ent;
         if (st.lt) begin
            hi_ff <= (i_ff > lo_ff) ? i_ff - 1'b1 : i_ff;
            k_ff  <= sart_pkg::CNT_W'(i_ff);
         end else if (st.le) begin
            hit_ff <= 1'b1;
            k_ff   <= sart_pkg::CNT_W'(i_ff);
         end else begin
            lo_ff <= i_ff + 1'b1;
            k_ff  <= sart_pkg::CNT_W'(i_ff) + 1'b1;
         end
      end
      if (cmd.ins_begin) begin
         j_ff <= count_ff;
      end else if (cmd.rm_begin) begin
         j_ff <= k_ff;
      end else if (cmd.ins_wr) begin
         j_ff <= j_ff - 1'b1;
      end else if (cmd.rm_wr) begin
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.res_load) begin
         res_st_ff  <= cmd.res_code;
         res_tag_ff <= '0;
         res_len_ff <= '0;
         res_off_ff <= '0;
         if (cmd.res_code == sart_pkg::ST_FOUND) begin
            res_tag_ff <= ent_ff.tag;
            res_len_ff <= ent_ff.len;
            res_off_ff <= sart_pkg::LEN_BITS'(a_ff - ent_ff.base);
         end
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {5'b0, res_off_ff, res_len_ff, res_tag_ff, res_st_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/core/sart_ctrl.sv
// Controller state machine: sequences search probes, entry shifts and updates.
// Depends on sart_pkg.
module sart_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sart_pkg::st_type  st,
   output sart_pkg::cmd_type cmd
);

   sart_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sart_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.upd      = sart_pkg::UPD_TAG;
      cmd.res_code = sart_pkg::ST_UNCHANGED;
      req_tready   = 1'b0;
      unique case (state_ff)
         sart_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sart_pkg::S_START;
            end
         end
         sart_pkg::S_START: begin
            if ((st.mode == sart_pkg::MODE_NONE) ||
                ((st.mode == sart_pkg::MODE_REMOVE) && st.skip_hit)) begin
               cmd.res_load = 1'b1;
               state_in     = sart_pkg::S_DONE;
            end else begin
               cmd.init = 1'b1;
               state_in = st.empty ? sart_pkg::S_ACT : sart_pkg::S_RD;
            end
         end
         sart_pkg::S_RD: begin
            cmd.probe_rd = 1'b1;
            state_in     = sart_pkg::S_CMP;
         end
         sart_pkg::S_CMP: begin
            cmd.probe_cmp = 1'b1;
            if (!st.lt && st.le) begin
               state_in = sart_pkg::S_ACT;
            end else begin
               state_in = st.lo_eq ? sart_pkg::S_ACT : sart_pkg::S_RD;
            end
         end
         sart_pkg::S_ACT: begin
            state_in     = sart_pkg::S_DONE;
            cmd.res_load = 1'b1;
            case (st.mode)
               sart_pkg::MODE_ADD: begin
                  if (!st.hit) begin
                     if (st.full) begin
                        cmd.res_code = sart_pkg::ST_FULL;
                     end else begin
                        cmd.res_load  = 1'b0;
                        cmd.ins_begin = 1'b1;
                        state_in      = sart_pkg::S_INS;
                     end
                  end else if (st.add_exact) begin
                     cmd.upd_wr   = 1'b1;
                     cmd.upd      = sart_pkg::UPD_TAG;
                     cmd.res_code = sart_pkg::ST_RENAMED;
                  end
               end
               sart_pkg::MODE_REMOVE: begin
                  if (!st.hit) begin
                     cmd.res_code = sart_pkg::ST_NOTFOUND;
                  end else if (st.rm_exact) begin
                     cmd.res_load = 1'b0;
                     cmd.rm_begin = 1'b1;
                     state_in     = sart_pkg::S_RMV;
                  end else if (st.base_eq) begin
                     cmd.upd_wr   = 1'b1;
                     cmd.upd      = sart_pkg::UPD_TRIM_START;
                     cmd.res_code = sart_pkg::ST_TRIMMED;
                  end else if (st.end_eq) begin
                     cmd.upd_wr   = 1'b1;
                     cmd.upd      = sart_pkg::UPD_TRIM_END;
                     cmd.res_code = sart_pkg::ST_TRIMMED;
                  end
               end
               sart_pkg::MODE_LOOKUP: begin
                  cmd.res_code = st.hit ? sart_pkg::ST_FOUND : sart_pkg::ST_NOTFOUND;
               end
               default: cmd.res_code = sart_pkg::ST_UNCHANGED;
            endcase
         end
         sart_pkg::S_INS: begin
            if (st.ins_done) begin
               cmd.new_wr   = 1'b1;
               cmd.cnt_inc  = 1'b1;
               cmd.res_load = 1'b1;
               cmd.res_code = sart_pkg::ST_INSERTED;
               state_in     = sart_pkg::S_DONE;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = sart_pkg::S_INSW;
            end
         end
         sart_pkg::S_INSW: begin
            cmd.ins_wr = 1'b1;
            state_in   = sart_pkg::S_INS;
         end
         sart_pkg::S_RMV: begin
            if (st.rm_done) begin
               cmd.cnt_dec  = 1'b1;
               cmd.res_load = 1'b1;
               cmd.res_code = sart_pkg::ST_REMOVED;
               state_in     = sart_pkg::S_DONE;
            end else begin
               cmd.rm_rd = 1'b1;
               state_in  = sart_pkg::S_RMVW;
            end
         end
         sart_pkg::S_RMVW: begin
            cmd.rm_wr = 1'b1;
            state_in  = sart_pkg::S_RMV;
         end
         sart_pkg::S_DONE: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sart_pkg::S_IDLE;
            end
         end
         default: state_in = sart_pkg::S_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/sorted_address_range_table_unit.sv
// Sorted address range table: up to 128 regions kept in base order in one RAM.
// Requests on req_*, one result per request on rsp_*.
// Lookup and modify run a binary search, each probe a RAM read then a compare,
// at most eight probes over a full table. Add and remove then shift the entries
// above the slot one by one, each moved entry read and then written back through
// the RAM's single write port. One request is worked at a time; req_tready is
// high only when the controller is idle. The result sits in an output register,
// so a new request is taken while the previous result still waits on rsp_tready;
// a stalled result holds the next one in the controller until the register
// frees. Reset empties the table (entry count zero) and drops any pending
// result; no clearing pass is needed. Depends on sart_pkg, sart_ctrl, sart_dp.
module sorted_address_range_table_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // base_addr[47:0], length[79:48], tag_in[95:80], skip_null[96]
   input  logic [1:0]   req_tuser,  // mode[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata   // status[2:0], tag_out[18:3], region_length[50:19], offset[82:51]
);

   sart_pkg::cmd_type cmd;
   sart_pkg::st_type  st;

   sart_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   sart_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      st.count <= sart_pkg::CNT_W'(sart_pkg::DEPTH))
      else $error("entry count above depth");

   a_count_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.cnt_inc && cmd.cnt_dec))
      else $error("count grows and shrinks together");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in work");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrites one not yet transferred");

endmodule
